// ===== src/atrw_pkg.sv =====
`default_nettype none

package atrw_pkg;

  localparam int unsigned PRICE_BITS_DEF = 32;
  localparam int unsigned PERIOD_BITS    = 10;
  localparam int unsigned FRAC_EXT       = 16;
  localparam int unsigned OUT_BITS       = 32;
  localparam logic [PERIOD_BITS-1:0] DEFAULT_PERIOD = PERIOD_BITS'(14);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_UPDATE,
    ST_SMOOTH,
    ST_FINISH,
    ST_MEAN,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    OP_SEED,
    OP_UP,
    OP_DN
  } op_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== src/atrw_if.sv =====
`default_nettype none

interface atrw_bar_if #(
  parameter int unsigned PW = atrw_pkg::PRICE_BITS_DEF
) ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] high;
  logic [PW-1:0] low;
  logic [PW-1:0] close;
  logic          last;

  modport source (output valid, output high, output low, output close, output last,
                  input ready);
  modport sink   (input valid, input high, input low, input close, input last,
                  output ready);
endinterface

interface atrw_res_if ();
  logic                            valid;
  logic                            ready;
  logic [atrw_pkg::OUT_BITS-1:0]   atr_value;
  logic                            valid_res;

  modport source (output valid, output atr_value, output valid_res, input ready);
  modport sink   (input valid, input atr_value, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== src/average_true_range_wilder.sv =====
`default_nettype none

// Channel   Dir  Payload                         Transaction
// bar_i     in   high, low, close, last          valid & ready
// atr_o     out  atr_value, valid_res            valid & ready
// cfg       in   period (cfg_wdata_i)            cfg_we_i
//
// A bar passes through range, update and finish states, plus a divide when the average is seeded or
// smoothed; a last bar adds a result state and, in the warm-up, a divide for the mean.
// The single radix-2 divider does each divide; bar_i is ready only in idle.
// Reset clears the series state and sets period to fourteen.
// A result waits in the output register while the next bar is taken; the block
// stalls before loading a new result until the previous one is taken.

module average_true_range_wilder #(
  parameter int unsigned PRICE_BITS = atrw_pkg::PRICE_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [atrw_pkg::PERIOD_BITS-1:0]      cfg_wdata_i,
  atrw_bar_if.sink                                   bar_i,
  atrw_res_if.source                                 atr_o
);

  localparam int unsigned PB = PRICE_BITS;
  localparam int unsigned PW = atrw_pkg::PERIOD_BITS;
  localparam int unsigned FX = atrw_pkg::FRAC_EXT;
  localparam int unsigned OB = atrw_pkg::OUT_BITS;
  localparam int unsigned SW = PB + PW;
  localparam int unsigned AW = PB + FX;
  localparam int unsigned DW = SW + FX;

  atrw_pkg::state_e    state_q, state_d;
  atrw_pkg::op_e       op_q;
  atrw_pkg::div_stat_t div_st;

  logic [PW-1:0]  period_q;
  logic [PW-1:0]  p_q;
  logic [PB-1:0]  high_q, low_q, close_q, prev_q, tr_q;
  logic           last_q, have_prev_q;
  logic [PW-1:0]  cnt_q;
  logic [SW-1:0]  sum_q;
  logic [AW-1:0]  avg_q;
  logic [OB-1:0]  res_val_q;
  logic           res_ok_q;
  logic [OB-1:0]  out_val_q;
  logic           out_ok_q, out_vld_q;

  logic [PB-1:0]  hl, da, db, tr;
  logic [SW-1:0]  sum_nx;
  logic [DW-1:0]  seed_dvd, x_ext, avg_ext, wil_dvd, avg_out;
  logic           up, warm, seed_now, out_free;
  logic           div_start;
  logic [DW-1:0]  div_dvd, div_q;
  logic [PW-1:0]  div_dvs;

  always_comb begin
    hl = (high_q >= low_q) ? high_q - low_q : '0;
    da = (high_q >= prev_q) ? high_q - prev_q : prev_q - high_q;
    db = (low_q >= prev_q) ? low_q - prev_q : prev_q - low_q;
    tr = hl;
    if (da > tr) tr = da;
    if (db > tr) tr = db;
  end

  assign sum_nx   = sum_q + SW'(tr_q);
  assign seed_dvd = DW'(sum_nx) << FX;
  assign x_ext    = DW'(tr_q) << FX;
  assign avg_ext  = DW'(avg_q);
  assign up       = x_ext >= avg_ext;
  assign wil_dvd  = up ? x_ext - avg_ext : avg_ext - x_ext + DW'(p_q) - DW'(1);
  assign warm     = cnt_q < p_q;
  assign seed_now = ({1'b0, cnt_q} + (PW + 1)'(1)) == {1'b0, p_q};
  assign out_free = !out_vld_q || atr_o.ready;
  assign avg_out  = DW'(avg_q >> FX);

  always_comb begin
    state_d = state_q;
    case (state_q)
      atrw_pkg::ST_IDLE:   if (bar_i.valid) state_d = atrw_pkg::ST_RANGE;
      atrw_pkg::ST_RANGE:  state_d = atrw_pkg::ST_UPDATE;
      atrw_pkg::ST_UPDATE: begin
        if (have_prev_q && (!warm || seed_now)) state_d = atrw_pkg::ST_SMOOTH;
        else state_d = atrw_pkg::ST_FINISH;
      end
      atrw_pkg::ST_SMOOTH: if (div_st.done) state_d = atrw_pkg::ST_FINISH;
      atrw_pkg::ST_FINISH: begin
        if (!last_q) state_d = atrw_pkg::ST_IDLE;
        else if (cnt_q != '0 && warm) state_d = atrw_pkg::ST_MEAN;
        else state_d = atrw_pkg::ST_RESULT;
      end
      atrw_pkg::ST_MEAN:   if (div_st.done) state_d = atrw_pkg::ST_RESULT;
      atrw_pkg::ST_RESULT: if (out_free) state_d = atrw_pkg::ST_IDLE;
      default:             state_d = atrw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    bar_i.ready = 1'b0;
    div_start   = 1'b0;
    div_dvd     = seed_dvd;
    div_dvs     = p_q;
    case (state_q)
      atrw_pkg::ST_IDLE:   bar_i.ready = 1'b1;
      atrw_pkg::ST_UPDATE: begin
        div_start = have_prev_q && (!warm || seed_now);
        div_dvd   = warm ? seed_dvd : wil_dvd;
      end
      atrw_pkg::ST_FINISH: begin
        div_start = last_q && cnt_q != '0 && warm;
        div_dvd   = DW'(sum_q);
        div_dvs   = cnt_q;
      end
      default: ;
    endcase
  end

  atrw_div #(
    .DW  (DW),
    .DVW (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_q),
    .stat_o     (div_st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atrw_pkg::ST_IDLE;
      period_q    <= atrw_pkg::DEFAULT_PERIOD;
      have_prev_q <= 1'b0;
      cnt_q       <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      prev_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) period_q <= cfg_wdata_i;
      if (state_q == atrw_pkg::ST_RESULT && out_free) out_vld_q <= 1'b1;
      else if (atr_o.ready) out_vld_q <= 1'b0;
      case (state_q)
        atrw_pkg::ST_UPDATE: begin
          if (have_prev_q && warm) begin
            sum_q <= sum_nx;
            cnt_q <= cnt_q + PW'(1);
          end
          prev_q      <= close_q;
          have_prev_q <= 1'b1;
        end
        atrw_pkg::ST_SMOOTH: begin
          if (div_st.done) begin
            case (op_q)
              atrw_pkg::OP_SEED: avg_q <= div_q[AW-1:0];
              atrw_pkg::OP_UP:   avg_q <= avg_q + div_q[AW-1:0];
              atrw_pkg::OP_DN:   avg_q <= avg_q - div_q[AW-1:0];
              default:           avg_q <= avg_q;
            endcase
          end
        end
        atrw_pkg::ST_RESULT: begin
          if (out_free) begin
            have_prev_q <= 1'b0;
            cnt_q       <= '0;
            sum_q       <= '0;
            avg_q       <= '0;
            prev_q      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      atrw_pkg::ST_IDLE: begin
        if (bar_i.valid) begin
          high_q  <= bar_i.high;
          low_q   <= bar_i.low;
          close_q <= bar_i.close;
          last_q  <= bar_i.last;
          p_q     <= (period_q == '0) ? atrw_pkg::DEFAULT_PERIOD : period_q;
        end
      end
      atrw_pkg::ST_RANGE:  tr_q <= tr;
      atrw_pkg::ST_UPDATE: begin
        if (warm) op_q <= atrw_pkg::OP_SEED;
        else if (up) op_q <= atrw_pkg::OP_UP;
        else op_q <= atrw_pkg::OP_DN;
      end
      atrw_pkg::ST_FINISH: begin
        res_ok_q  <= cnt_q != '0;
        res_val_q <= (cnt_q == '0) ? '0 : avg_out[OB-1:0];
      end
      atrw_pkg::ST_MEAN:   if (div_st.done) res_val_q <= div_q[OB-1:0];
      atrw_pkg::ST_RESULT: begin
        if (out_free) begin
          out_val_q <= res_val_q;
          out_ok_q  <= res_ok_q;
        end
      end
      default: ;
    endcase
  end

  assign atr_o.valid     = out_vld_q;
  assign atr_o.atr_value = out_val_q;
  assign atr_o.valid_res = out_ok_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == atrw_pkg::ST_SMOOTH || state_q == atrw_pkg::ST_MEAN))
    else $error("divider finished outside a wait state");

  a_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atrw_pkg::ST_SMOOTH || state_q == atrw_pkg::ST_MEAN)
      |-> (div_st.busy || div_st.done))
    else $error("waiting on an idle divider");

  a_series_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atrw_pkg::ST_RESULT && out_free)
      |=> (!have_prev_q && cnt_q == '0 && out_vld_q))
    else $error("series state not cleared after result");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bar_i.valid && bar_i.ready) |=> state_q == atrw_pkg::ST_RANGE)
    else $error("accepted bar not processed");

endmodule

`default_nettype wire

// ===== src/atrw_div.sv =====
`default_nettype none

module atrw_div #(
  parameter int unsigned DW  = 58,
  parameter int unsigned DVW = atrw_pkg::PERIOD_BITS
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DW-1:0]   dividend_i,
  input  wire logic [DVW-1:0]  divisor_i,
  output logic [DW-1:0]        quotient_o,
  output atrw_pkg::div_stat_t  stat_o
);

  localparam int unsigned CW = $clog2(DW + 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [DVW-1:0]  rem_q, rem_d;
  logic [DW-1:0]   quo_q, quo_d;
  logic [DVW-1:0]  dvs_q, dvs_d;
  logic [DVW:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[DW-1]} - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[DVW]) begin
        rem_d = trial[DVW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DVW-2:0], quo_q[DW-1]};
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ===== bench/average_true_range_wilder_tb.sv =====
module average_true_range_wilder_tb;

  localparam int unsigned PW         = atrw_pkg::PRICE_BITS_DEF;
  localparam int unsigned SETTLE     = 200;
  localparam int unsigned QUIET_MAX  = 5000;
  localparam int unsigned MIN_BARS   = 500;
  localparam int unsigned MIN_SERIES = 30;

  typedef struct packed {
    logic [PW-1:0] high;
    logic [PW-1:0] low;
    logic [PW-1:0] close;
    logic          last;
  } bar_t;

  typedef struct packed {
    logic [atrw_pkg::OUT_BITS-1:0] atr;
    logic                          valid_res;
  } atr_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we;
  logic [atrw_pkg::PERIOD_BITS-1:0] cfg_wdata;

  atrw_bar_if #(.PW(PW)) bar_if ();
  atrw_res_if            atr_if ();

  average_true_range_wilder #(.PRICE_BITS(PW)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .bar_i       (bar_if),
    .atr_o       (atr_if)
  );

  bar_t        bars_pending[$];
  atr_t        atr_expected[$];
  int unsigned bar_idle;
  int unsigned res_idle;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned bars_queued;
  int unsigned series_queued;
  logic [PW-1:0] mid_price;

  // series state of the predicted block
  logic [atrw_pkg::PERIOD_BITS-1:0] period_reg;
  logic [PW-1:0]                    last_close;
  logic                             prev_seen;
  logic [atrw_pkg::PERIOD_BITS-1:0] ranges_seen;
  logic [41:0]                      range_total;
  logic [47:0]                      atr_acc;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] price_gap(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a >= b) ? 64'(a - b) : 64'(b - a);
  endfunction

  task automatic clear_series();
    last_close  = '0;
    prev_seen   = 1'b0;
    ranges_seen = '0;
    range_total = '0;
    atr_acc     = '0;
  endtask

  task automatic advance_atr(input bar_t b);
    logic [63:0] p;
    logic [63:0] tr;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] avg;
    atr_t        res;
    p = (period_reg != '0) ? 64'(period_reg) : 64'(atrw_pkg::DEFAULT_PERIOD);
    if (prev_seen) begin
      tr = (b.high >= b.low) ? 64'(b.high - b.low) : 64'd0;
      if (price_gap(b.high, last_close) > tr) tr = price_gap(b.high, last_close);
      if (price_gap(b.low, last_close) > tr) tr = price_gap(b.low, last_close);
      if (64'(ranges_seen) < p) begin
        range_total = range_total + tr[41:0];
        ranges_seen = ranges_seen + atrw_pkg::PERIOD_BITS'(1);
        if (64'(ranges_seen) == p) begin
          q = 64'(range_total) / p;
          r = 64'(range_total) % p;
          atr_acc = 48'((q << atrw_pkg::FRAC_EXT) + ((r << atrw_pkg::FRAC_EXT) / p));
        end
      end else begin
        x   = tr << atrw_pkg::FRAC_EXT;
        avg = 64'(atr_acc);
        if (x >= avg) avg = avg + (x - avg) / p;
        else avg = avg - ((avg - x) + p - 64'd1) / p;
        atr_acc = avg[47:0];
      end
    end
    last_close = b.close;
    prev_seen  = 1'b1;
    if (b.last) begin
      if (ranges_seen == '0) begin
        res.atr       = '0;
        res.valid_res = 1'b0;
      end else if (64'(ranges_seen) < p) begin
        res.atr       = 32'(64'(range_total) / 64'(ranges_seen));
        res.valid_res = 1'b1;
      end else begin
        res.atr       = atr_acc[47:16];
        res.valid_res = 1'b1;
      end
      atr_expected = {atr_expected, res};
      clear_series();
    end
  endtask

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  // bar driver; prediction runs on each accepted transaction
  always @(posedge clk_i) begin : drive_bars
    bar_t nxt;
    if (rst_ni) begin
      if (bar_if.valid && bar_if.ready)
        advance_atr('{high: bar_if.high, low: bar_if.low, close: bar_if.close,
                      last: bar_if.last});
      if (!bar_if.valid || bar_if.ready) begin
        if (bars_pending.size() != 0 && $urandom_range(99) >= bar_idle) begin
          nxt = bars_pending.pop_front();
          bar_if.valid <= 1'b1;
          bar_if.high  <= nxt.high;
          bar_if.low   <= nxt.low;
          bar_if.close <= nxt.close;
          bar_if.last  <= nxt.last;
        end else begin
          bar_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch_results
    atr_t want;
    if (rst_ni) begin
      if (atr_if.valid && atr_if.ready) begin
        if (atr_expected.size() == 0) begin
          flag("unexpected result", '0, atr_if.atr_value);
        end else begin
          want = atr_expected.pop_front();
          if (want.atr !== atr_if.atr_value) flag("atr_value", want.atr, atr_if.atr_value);
          if (want.valid_res !== atr_if.valid_res)
            flag("valid_res", 32'(want.valid_res), 32'(atr_if.valid_res));
        end
      end
      atr_if.ready <= ($urandom_range(99) >= res_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((bar_if.valid && bar_if.ready) || (atr_if.valid && atr_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("FAIL average_true_range_wilder");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_bar(input logic [PW-1:0] h, input logic [PW-1:0] l,
                          input logic [PW-1:0] c, input logic fin);
    bar_t b;
    b.high  = h;
    b.low   = l;
    b.close = c;
    b.last  = fin;
    bars_pending = {bars_pending, b};
    bars_queued++;
    if (fin) series_queued++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (bars_pending.size() != 0 || atr_expected.size() != 0 || bar_if.valid)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_period(input logic [atrw_pkg::PERIOD_BITS-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    period_reg = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_bar(input logic fin);
    logic [PW-1:0] h;
    logic [PW-1:0] l;
    logic [PW-1:0] c;
    logic [PW-1:0] up;
    logic [PW-1:0] dn;
    logic [PW-1:0] step;
    int unsigned   pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      h = $urandom;
      l = $urandom;
      c = $urandom;
    end else if (pick < 12) begin
      h = $urandom_range(1) ? '1 : '0;
      l = $urandom_range(1) ? '1 : '0;
      c = $urandom_range(1) ? '1 : '0;
    end else begin
      step = $urandom_range(32'h3FFFF);
      if ($urandom_range(1) && mid_price < 32'hFFE0_0000) mid_price = mid_price + step;
      else if (mid_price > 32'h0020_0000) mid_price = mid_price - step;
      up = $urandom_range(32'h3FFFF);
      dn = $urandom_range(32'h3FFFF);
      h  = mid_price + up;
      l  = mid_price - dn;
      c  = l + $urandom_range(up + dn);
      if (pick < 17) begin
        up = h;
        h  = l;
        l  = up;
      end
    end
    push_bar(h, l, c, fin);
  endtask

  task automatic random_series(input int unsigned n, input logic fin);
    for (int unsigned i = 1; i <= n; i++) random_bar(fin && i == n);
  endtask

  initial begin
    int unsigned p;
    int unsigned n;
    int unsigned phase;
    logic [atrw_pkg::PERIOD_BITS-1:0] pv;
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    bar_if.valid = 1'b0;
    bar_if.high  = '0;
    bar_if.low   = '0;
    bar_if.close = '0;
    bar_if.last  = 1'b0;
    atr_if.ready = 1'b0;
    bar_idle     = 21;
    res_idle     = 21;
    mismatches   = 0;
    quiet_cycles = 0;
    bars_queued  = 0;
    series_queued = 0;
    mid_price    = 32'h0100_0000;
    period_reg   = atrw_pkg::DEFAULT_PERIOD;
    clear_series();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // lone bar, full-scale range, low above high
    push_bar('1, '0, 32'h1234_5678, 1'b1);
    push_bar('1, '0, '0, 1'b0);
    push_bar('1, '0, '1, 1'b1);
    push_bar(32'h0001_0000, 32'h0000_8000, 32'h0000_C000, 1'b0);
    push_bar(32'h0000_4000, 32'h0003_0000, 32'h0002_0000, 1'b1);

    set_period(10'd1);
    push_bar(32'h0010_0000, 32'h000F_0000, 32'h000F_8000, 1'b0);
    push_bar(32'h0014_0000, 32'h000E_0000, 32'h0012_0000, 1'b0);
    push_bar(32'h0012_1000, 32'h0011_F000, 32'h0012_0000, 1'b1);

    set_period(10'd2);
    push_bar(32'h0010_0000, 32'h000F_0000, 32'h000F_8000, 1'b0);
    push_bar(32'h0010_3333, 32'h000F_1111, 32'h000F_8000, 1'b0);
    push_bar(32'h0011_7777, 32'h000E_0001, 32'h0010_0000, 1'b0);
    push_bar(32'h0019_0000, 32'h000A_0000, 32'h0010_0000, 1'b0);
    push_bar(32'h0010_0005, 32'h0010_0000, 32'h0010_0003, 1'b1);

    set_period(10'd0);
    random_series(4, 1'b1);
    random_series(3, 1'b0);
    set_period(10'd2);
    random_bar(1'b1);

    set_period(10'd1023);
    random_series(10, 1'b0);
    set_period(10'd3);
    random_series(2, 1'b1);
    set_period(10'd1023);
    random_series(10, 1'b0);
    set_period(10'd20);
    random_series(14, 1'b1);

    phase = 0;
    while (bars_queued < MIN_BARS || series_queued < MIN_SERIES) begin
      n = $urandom_range(99);
      if (n < 5) pv = '0;
      else if (n < 10) pv = '1;
      else if (n < 15) pv = atrw_pkg::PERIOD_BITS'($urandom_range(1023));
      else pv = atrw_pkg::PERIOD_BITS'($urandom_range(1, 24));
      set_period(pv);
      p = (pv == '0) ? 32'(atrw_pkg::DEFAULT_PERIOD) : 32'(pv);
      bar_idle = (phase >= 3 && phase < 7) ? 0 : 21;
      res_idle = (phase >= 3 && phase < 7) ? 0 : 21;
      repeat ($urandom_range(1, 4)) begin
        if (p > 60) n = $urandom_range(1, 40);
        else if ($urandom_range(99) < 60) n = $urandom_range(1, p + 2);
        else n = $urandom_range(p, 3 * p + 4);
        random_series(n, 1'b1);
      end
      if ($urandom_range(3) == 0) random_series($urandom_range(1, (p > 60) ? 20 : p + 3), 1'b0);
      phase++;
    end

    wait_idle();
    if (mismatches == 0 && atr_expected.size() == 0) begin
      $display("PASS average_true_range_wilder");
    end else begin
      $display("FAIL average_true_range_wilder");
    end
    $finish;
  end

endmodule
